/* sv/filtered_message_queue_assert.svh */
// ----------------------------------------------------------------------------
// filtered_message_queue_assert.svh
// assertion macros for the filtered message queue datapath
// ----------------------------------------------------------------------------
`ifndef FILTERED_MESSAGE_QUEUE_ASSERT_SVH
`define FILTERED_MESSAGE_QUEUE_ASSERT_SVH

// generic form with explicit clock and reset
`define FMQ_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// default form on the block clock and reset
`define FMQ_ASSERT(lbl, prop, msg) `FMQ_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

/* sv/fmq_pkg.sv */
// ----------------------------------------------------------------------------
// fmq_pkg
// types, codes and sizes shared by the filtered message queue
// ----------------------------------------------------------------------------
package fmq_pkg;

   localparam int DEPTH       = 16;
   localparam int SENDER_BITS = 8;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   // fixed field widths of the ports
   localparam int MODE_W     = 2;
   localparam int PRIO_W     = 2;
   localparam int KIND_W     = 3;
   localparam int SENDER_W   = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FETCH = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_MATCH = 2'd2;

   typedef struct packed {
      logic [PRIO_W-1:0]      prio;
      logic [KIND_W-1:0]      kind;
      logic [SENDER_BITS-1:0] sender;
   } entry_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;
   } stat_type;

endpackage

/* sv/fmq_ctrl.sv */
// ----------------------------------------------------------------------------
// fmq_ctrl
// sequencer: captures a transaction, then commits it into the queue
// ----------------------------------------------------------------------------
module fmq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fmq_pkg::stat_type stat,
   output fmq_pkg::cmd_type  cmd
);

   fmq_pkg::state_type state_ff;
   fmq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fmq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fmq_pkg::ST_COMMIT;
            end
         end
         fmq_pkg::ST_COMMIT: begin
            if (stat.slot_free) begin
               state_in = fmq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fmq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         fmq_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         fmq_pkg::ST_COMMIT: begin
            // hold until the result register can take the answer
            cmd.commit = stat.slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* sv/fmq_datapath.sv */
// ----------------------------------------------------------------------------
// fmq_datapath
// entry registers, parallel filter match, compaction and result register
// ----------------------------------------------------------------------------
`include "filtered_message_queue_assert.svh"

module fmq_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  fmq_pkg::cmd_type                   cmd,
   output fmq_pkg::stat_type                  stat,
   input  logic [fmq_pkg::MODE_W-1:0]         req_mode,
   input  logic [fmq_pkg::PRIO_W-1:0]         req_prio,
   input  logic                               req_prio_any,
   input  logic [fmq_pkg::KIND_W-1:0]         req_kind,
   input  logic                               req_kind_any,
   input  logic [fmq_pkg::SENDER_W-1:0]       req_sender_id,
   input  logic                               req_sender_any,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fmq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fmq_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic [fmq_pkg::PRIO_W-1:0]         rsp_out_prio,
   output logic [fmq_pkg::KIND_W-1:0]         rsp_out_kind,
   output logic [fmq_pkg::SENDER_W-1:0]       rsp_out_sender,
   output logic [fmq_pkg::COUNT_W-1:0]        rsp_fill_level
);

   fmq_pkg::entry_type                 store_ff [fmq_pkg::DEPTH];
   fmq_pkg::entry_type                 store_in [fmq_pkg::DEPTH];
   logic [fmq_pkg::CNT_W-1:0]          count_ff;
   logic [fmq_pkg::CNT_W-1:0]          count_in;

   // captured transaction
   logic [fmq_pkg::MODE_W-1:0]         mode_ff;
   fmq_pkg::entry_type                 item_ff;
   logic [fmq_pkg::DEPTH-1:0]          match_ff;
   logic [fmq_pkg::DEPTH-1:0]          match_in;
   logic [fmq_pkg::DEPTH-1:0]          live_mask;
   logic [fmq_pkg::SENDER_BITS-1:0]    req_sender;

   // result register
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [fmq_pkg::STATUS_W-1:0]       status_ff;
   logic [fmq_pkg::STATUS_W-1:0]       status_in;
   logic [fmq_pkg::COUNT_W-1:0]        hits_ff;
   logic [fmq_pkg::COUNT_W-1:0]        hits_in;
   fmq_pkg::entry_type                 out_ff;
   fmq_pkg::entry_type                 out_in;
   logic [fmq_pkg::COUNT_W-1:0]        fill_ff;

   logic [fmq_pkg::CNT_W-1:0]          hits;
   logic [fmq_pkg::IDX_W-1:0]          first_idx;
   logic                               found;
   logic                               full;
   logic                               do_add;
   logic                               do_fetch;

   assign req_sender = fmq_pkg::SENDER_BITS'(req_sender_id);

   // entries at and above the fill level are not part of the queue
   always_comb begin
      for (int i = 0; i < fmq_pkg::DEPTH; i++) begin
         live_mask[i] = (fmq_pkg::CNT_W'(i) < count_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < fmq_pkg::DEPTH; i++) begin
         match_in[i] = live_mask[i]
                     & (req_prio_any   | (store_ff[i].prio   == req_prio))
                     & (req_kind_any   | (store_ff[i].kind   == req_kind))
                     & (req_sender_any | (store_ff[i].sender == req_sender));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff        <= req_mode;
         item_ff.prio   <= req_prio;
         item_ff.kind   <= req_kind;
         item_ff.sender <= req_sender;
         match_ff       <= match_in;
      end
   end

   // oldest match wins
   always_comb begin
      first_idx = '0;
      for (int i = fmq_pkg::DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            first_idx = fmq_pkg::IDX_W'(i);
         end
      end
   end

   assign found    = |match_ff;
   assign hits     = fmq_pkg::CNT_W'($countones(match_ff));
   assign full     = (count_ff == fmq_pkg::DEPTH_CNT);
   assign do_add   = cmd.commit && (mode_ff == fmq_pkg::MODE_ADD) && !full;
   assign do_fetch = cmd.commit && (mode_ff == fmq_pkg::MODE_FETCH) && found;

   always_comb begin
      for (int i = 0; i < fmq_pkg::DEPTH; i++) begin
         store_in[i] = store_ff[i];
         if (do_add && (count_ff == fmq_pkg::CNT_W'(i))) begin
            store_in[i] = item_ff;
         end
      end
      // close the gap left by the fetched entry
      for (int i = 0; i < fmq_pkg::DEPTH - 1; i++) begin
         if (do_fetch && (fmq_pkg::IDX_W'(i) >= first_idx)) begin
            store_in[i] = store_ff[i + 1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_add) begin
         count_in = count_ff + 1'b1;
      end else if (do_fetch) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < fmq_pkg::DEPTH; i++) begin
         store_ff[i] <= store_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      status_in = fmq_pkg::STAT_OK;
      hits_in   = '0;
      out_in    = '0;
      case (mode_ff)
         fmq_pkg::MODE_ADD: begin
            if (full) begin
               status_in = fmq_pkg::STAT_FULL;
            end
         end
         fmq_pkg::MODE_COUNT: begin
            hits_in = fmq_pkg::COUNT_W'(hits);
         end
         fmq_pkg::MODE_FETCH: begin
            if (found) begin
               out_in = store_ff[first_idx];
            end else begin
               status_in = fmq_pkg::STAT_NO_MATCH;
            end
         end
         default: begin
            status_in = fmq_pkg::STAT_OK;
         end
      endcase
   end

   assign stat.slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         hits_ff   <= hits_in;
         out_ff    <= out_in;
         fill_ff   <= fmq_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_match_count = hits_ff;
   assign rsp_out_prio    = out_ff.prio;
   assign rsp_out_kind    = out_ff.kind;
   assign rsp_out_sender  = fmq_pkg::SENDER_W'(out_ff.sender);
   assign rsp_fill_level  = fill_ff;

   `FMQ_ASSERT(a_count_bound, count_ff <= fmq_pkg::DEPTH_CNT, "fill count beyond depth")
   `FMQ_ASSERT(a_match_live, cmd.commit |-> ((match_ff & ~live_mask) == '0), "match on dead entry")
   `FMQ_ASSERT(a_add_grows, do_add |=> (count_ff == $past(count_ff) + 1'b1), "add lost")
   `FMQ_ASSERT(a_fetch_shrinks, do_fetch |=> (count_ff == $past(count_ff) - 1'b1), "fetch lost")
   `FMQ_ASSERT(a_rsp_from_commit, $rose(rsp_valid_ff) |-> $past(cmd.commit), "stray response")

endmodule

/* sv/filtered_message_queue.sv */
// a transaction is captured in the idle step and committed in the commit step, which registers the response
// the sequencer takes no new request until the commit step of the last one is done
// a stalled response holds the commit step; no new request is taken while it waits
// reset (synchronous, active high) empties the queue and drops any pending response
// ----------------------------------------------------------------------------
// filtered_message_queue
// mailbox queue with add, filtered count and filtered fetch of the oldest match
// ----------------------------------------------------------------------------
module filtered_message_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [fmq_pkg::MODE_W-1:0]         req_mode,
   input  logic [fmq_pkg::PRIO_W-1:0]         req_prio,
   input  logic                               req_prio_any,
   input  logic [fmq_pkg::KIND_W-1:0]         req_kind,
   input  logic                               req_kind_any,
   input  logic [fmq_pkg::SENDER_W-1:0]       req_sender_id,
   input  logic                               req_sender_any,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fmq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fmq_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic [fmq_pkg::PRIO_W-1:0]         rsp_out_prio,
   output logic [fmq_pkg::KIND_W-1:0]         rsp_out_kind,
   output logic [fmq_pkg::SENDER_W-1:0]       rsp_out_sender,
   output logic [fmq_pkg::COUNT_W-1:0]        rsp_fill_level
);

   fmq_pkg::cmd_type  cmd;
   fmq_pkg::stat_type stat;

   fmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fmq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_mode),
      .req_prio        (req_prio),
      .req_prio_any    (req_prio_any),
      .req_kind        (req_kind),
      .req_kind_any    (req_kind_any),
      .req_sender_id   (req_sender_id),
      .req_sender_any  (req_sender_any),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_match_count (rsp_match_count),
      .rsp_out_prio    (rsp_out_prio),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_sender  (rsp_out_sender),
      .rsp_fill_level  (rsp_fill_level)
   );

endmodule

/* verif/tb_filtered_message_queue.sv */
// ----------------------------------------------------------------------------
// tb_filtered_message_queue
// Self-checking testbench for the filtered message queue. Requests go in over
// the req_ channel and responses come back over the rsp_ channel, with random
// gaps on the request side and random stalls on the response side. Each
// accepted request goes through a queue model held in the testbench, and the
// result is compared field by field with the response that comes back in
// order. The stimulus is a directed pass, a full-queue pass and a long random
// pass. The random pass runs fill-heavy, drain-heavy and balanced phases; most
// of its filters are built from entries that are in the queue at the time.
// ----------------------------------------------------------------------------
module tb_filtered_message_queue;
   timeunit 1ns;
   timeprecision 1ps;

   // mode value with no operation behind it
   localparam logic [fmq_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

   localparam int PRIO_SPAM      = 0;
   localparam int PRIO_BATCH     = 1;
   localparam int PRIO_NORMAL    = 2;
   localparam int PRIO_INTERRUPT = 3;
   localparam int KIND_INFO      = 0;
   localparam int KIND_SYSTEM    = 4;
   localparam int KIND_SPARE_LO  = 5;
   localparam int KIND_SPARE_HI  = 7;

   localparam int PHASE_ITEMS = 60;
   localparam int PHASES      = 25;

   typedef struct packed {
      logic [fmq_pkg::MODE_W-1:0]   mode;
      logic [fmq_pkg::PRIO_W-1:0]   prio;
      logic                         prio_any;
      logic [fmq_pkg::KIND_W-1:0]   kind;
      logic                         kind_any;
      logic [fmq_pkg::SENDER_W-1:0] sender;
      logic                         sender_any;
   } mailbox_req_type;

   typedef struct packed {
      logic [fmq_pkg::STATUS_W-1:0] status;
      logic [fmq_pkg::COUNT_W-1:0]  match_count;
      logic [fmq_pkg::PRIO_W-1:0]   prio;
      logic [fmq_pkg::KIND_W-1:0]   kind;
      logic [fmq_pkg::SENDER_W-1:0] sender;
      logic [fmq_pkg::COUNT_W-1:0]  fill;
   } mailbox_rsp_type;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic                         req_stall;
   logic [fmq_pkg::MODE_W-1:0]   req_mode       = '0;
   logic [fmq_pkg::PRIO_W-1:0]   req_prio       = '0;
   logic                         req_prio_any   = 1'b0;
   logic [fmq_pkg::KIND_W-1:0]   req_kind       = '0;
   logic                         req_kind_any   = 1'b0;
   logic [fmq_pkg::SENDER_W-1:0] req_sender_id  = '0;
   logic                         req_sender_any = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall      = 1'b0;
   logic [fmq_pkg::STATUS_W-1:0] rsp_status;
   logic [fmq_pkg::COUNT_W-1:0]  rsp_match_count;
   logic [fmq_pkg::PRIO_W-1:0]   rsp_out_prio;
   logic [fmq_pkg::KIND_W-1:0]   rsp_out_kind;
   logic [fmq_pkg::SENDER_W-1:0] rsp_out_sender;
   logic [fmq_pkg::COUNT_W-1:0]  rsp_fill_level;

   fmq_pkg::entry_type mailbox_model[$];
   mailbox_rsp_type    replies_due[$];
   int                 error_count  = 0;
   int                 stall_left   = 0;
   bit                 tight_timing = 1'b0;

   filtered_message_queue uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_prio        (req_prio),
      .req_prio_any    (req_prio_any),
      .req_kind        (req_kind),
      .req_kind_any    (req_kind_any),
      .req_sender_id   (req_sender_id),
      .req_sender_any  (req_sender_any),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_match_count (rsp_match_count),
      .rsp_out_prio    (rsp_out_prio),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_out_sender  (rsp_out_sender),
      .rsp_fill_level  (rsp_fill_level)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic bit entry_hit(fmq_pkg::entry_type e, mailbox_req_type f);
      bit p_ok;
      bit k_ok;
      bit s_ok;
      p_ok = f.prio_any || (e.prio == f.prio);
      k_ok = f.kind_any || (e.kind == f.kind);
      s_ok = f.sender_any || (e.sender == fmq_pkg::SENDER_BITS'(f.sender));
      return p_ok && k_ok && s_ok;
   endfunction

   function automatic mailbox_rsp_type apply_to_mailbox(mailbox_req_type it);
      mailbox_rsp_type    r;
      fmq_pkg::entry_type e;
      int                 hits;
      int                 first;
      r     = '0;
      hits  = 0;
      first = -1;
      case (it.mode)
         fmq_pkg::MODE_ADD: begin
            if (mailbox_model.size() >= fmq_pkg::DEPTH) begin
               r.status = fmq_pkg::STAT_FULL;
            end else begin
               e.prio   = it.prio;
               e.kind   = it.kind;
               e.sender = fmq_pkg::SENDER_BITS'(it.sender);
               mailbox_model.push_back(e);
            end
         end
         fmq_pkg::MODE_COUNT: begin
            foreach (mailbox_model[i])
               if (entry_hit(mailbox_model[i], it))
                  hits++;
            r.match_count = fmq_pkg::COUNT_W'(hits);
         end
         fmq_pkg::MODE_FETCH: begin
            foreach (mailbox_model[i])
               if (first < 0 && entry_hit(mailbox_model[i], it))
                  first = i;
            if (first < 0) begin
               r.status = fmq_pkg::STAT_NO_MATCH;
            end else begin
               r.prio   = mailbox_model[first].prio;
               r.kind   = mailbox_model[first].kind;
               r.sender = fmq_pkg::SENDER_W'(mailbox_model[first].sender);
               mailbox_model.delete(first);
            end
         end
         default: ;
      endcase
      r.fill = fmq_pkg::COUNT_W'(mailbox_model.size());
      return r;
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tight_timing || r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic mailbox_req_type make_item(logic [fmq_pkg::MODE_W-1:0] mode,
                                                 int prio, bit pa, int kind, bit ka,
                                                 int sender, bit sa);
      mailbox_req_type it;
      it.mode       = mode;
      it.prio       = fmq_pkg::PRIO_W'(prio);
      it.prio_any   = pa;
      it.kind       = fmq_pkg::KIND_W'(kind);
      it.kind_any   = ka;
      it.sender     = fmq_pkg::SENDER_W'(sender);
      it.sender_any = sa;
      return it;
   endfunction

   // a small set of senders so that entries repeat and filters hit several
   function automatic int pick_sender();
      int r;
      r = $urandom_range(0, 99);
      case (r % 4)
         0: if (r < 60) return 8'h00;
         1: if (r < 60) return 8'h01;
         2: if (r < 60) return 8'h80;
         default: if (r < 60) return 8'hFF;
      endcase
      return $urandom_range(0, 255);
   endfunction

   function automatic int pick_kind();
      if ($urandom_range(0, 99) < 75)
         return $urandom_range(KIND_INFO, KIND_SYSTEM);
      return $urandom_range(KIND_SPARE_LO, KIND_SPARE_HI);
   endfunction

   function automatic mailbox_req_type make_random_item(int add_pct, int fetch_pct);
      mailbox_req_type    it;
      fmq_pkg::entry_type e;
      int                 r;
      r  = $urandom_range(0, 99);
      it = make_item(fmq_pkg::MODE_COUNT, $urandom_range(0, 3), $urandom_range(0, 3) == 0,
                     pick_kind(), $urandom_range(0, 3) == 0,
                     pick_sender(), $urandom_range(0, 3) == 0);
      if (r < 4) begin
         it.mode = MODE_NONE;
      end else if (r < 4 + add_pct) begin
         it.mode       = fmq_pkg::MODE_ADD;
         it.prio_any   = 1'($urandom_range(0, 1));
         it.kind_any   = 1'($urandom_range(0, 1));
         it.sender_any = 1'($urandom_range(0, 1));
      end else begin
         it.mode = (r < 4 + add_pct + fetch_pct) ? fmq_pkg::MODE_FETCH : fmq_pkg::MODE_COUNT;
         // most filters aim at an entry that is held, some miss on purpose
         if (mailbox_model.size() != 0 && $urandom_range(0, 99) < 85) begin
            e             = mailbox_model[$urandom_range(0, mailbox_model.size() - 1)];
            it.prio       = e.prio;
            it.kind       = e.kind;
            it.sender     = fmq_pkg::SENDER_W'(e.sender);
            it.prio_any   = $urandom_range(0, 99) < 30;
            it.kind_any   = $urandom_range(0, 99) < 30;
            it.sender_any = $urandom_range(0, 99) < 30;
            if ($urandom_range(0, 99) < 15)
               it.sender = fmq_pkg::SENDER_W'(pick_sender());
         end
      end
      return it;
   endfunction

   // called at a rising edge; returns at the edge where the transaction is taken, or after the random gap that follows
   task automatic send_item(mailbox_req_type it);
      int gap;
      req_valid      <= 1'b1;
      req_mode       <= it.mode;
      req_prio       <= it.prio;
      req_prio_any   <= it.prio_any;
      req_kind       <= it.kind;
      req_kind_any   <= it.kind_any;
      req_sender_id  <= it.sender;
      req_sender_any <= it.sender_any;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      replies_due.push_back(apply_to_mailbox(it));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      mailbox_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (replies_due.size() == 0) begin
            report_mismatch("response with none pending", 32'(rsp_status), 32'd0);
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_match_count !== want.match_count)
               report_mismatch("match_count", 32'(rsp_match_count), 32'(want.match_count));
            if (rsp_out_prio !== want.prio)
               report_mismatch("out_prio", 32'(rsp_out_prio), 32'(want.prio));
            if (rsp_out_kind !== want.kind)
               report_mismatch("out_kind", 32'(rsp_out_kind), 32'(want.kind));
            if (rsp_out_sender !== want.sender)
               report_mismatch("out_sender", 32'(rsp_out_sender), 32'(want.sender));
            if (rsp_fill_level !== want.fill)
               report_mismatch("fill_level", 32'(rsp_fill_level), 32'(want.fill));
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left = pick_gap();
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      send_item(make_item(fmq_pkg::MODE_FETCH, PRIO_SPAM, 1, KIND_INFO, 1, 0, 1));
      send_item(make_item(fmq_pkg::MODE_COUNT, PRIO_SPAM, 1, KIND_INFO, 1, 0, 1));
      send_item(make_item(MODE_NONE, PRIO_INTERRUPT, 1, KIND_SPARE_HI, 1, 8'hFF, 1));
      // wildcard bits on an add must not matter
      send_item(make_item(fmq_pkg::MODE_ADD, PRIO_SPAM, 1, KIND_INFO, 1, 8'h00, 1));
      send_item(make_item(fmq_pkg::MODE_ADD, PRIO_INTERRUPT, 0, KIND_SPARE_HI, 0, 8'hFF, 0));
      send_item(make_item(fmq_pkg::MODE_ADD, PRIO_NORMAL, 0, KIND_SYSTEM, 0, 8'h55, 0));
      send_item(make_item(fmq_pkg::MODE_ADD, PRIO_BATCH, 0, KIND_SPARE_LO, 0, 8'hAA, 0));
      send_item(make_item(fmq_pkg::MODE_ADD, PRIO_SPAM, 0, KIND_INFO, 0, 8'h00, 0));
      send_item(make_item(fmq_pkg::MODE_COUNT, PRIO_SPAM, 0, KIND_INFO, 0, 8'h00, 0));
      send_item(make_item(fmq_pkg::MODE_COUNT, PRIO_SPAM, 1, KIND_SPARE_HI, 0, 8'hFF, 0));
      send_item(make_item(fmq_pkg::MODE_COUNT, PRIO_NORMAL, 0, KIND_INFO, 1, 8'h55, 0));
      send_item(make_item(fmq_pkg::MODE_COUNT, PRIO_BATCH, 0, KIND_SPARE_LO, 0, 8'h00, 1));
      send_item(make_item(fmq_pkg::MODE_COUNT, PRIO_SPAM, 1, KIND_INFO, 1, 8'h00, 1));
      send_item(make_item(MODE_NONE, PRIO_SPAM, 0, KIND_INFO, 0, 8'h00, 0));
      // take one from the middle, the rest keep their order
      send_item(make_item(fmq_pkg::MODE_FETCH, PRIO_BATCH, 0, KIND_SPARE_LO, 0, 8'hAA, 0));
      send_item(make_item(fmq_pkg::MODE_FETCH, PRIO_INTERRUPT, 0, KIND_INFO, 0, 8'h00, 0));
      send_item(make_item(fmq_pkg::MODE_FETCH, PRIO_SPAM, 1, KIND_INFO, 1, 8'h00, 1));
      send_item(make_item(fmq_pkg::MODE_FETCH, PRIO_SPAM, 0, KIND_INFO, 0, 8'h00, 1));
      send_item(make_item(fmq_pkg::MODE_FETCH, PRIO_INTERRUPT, 0, KIND_SPARE_HI, 0, 8'hFF, 0));
      send_item(make_item(fmq_pkg::MODE_FETCH, PRIO_SPAM, 1, KIND_INFO, 1, 8'h00, 1));
      send_item(make_item(fmq_pkg::MODE_FETCH, PRIO_SPAM, 1, KIND_INFO, 1, 8'h00, 1));
      pause_until_drained();
   endtask

   task automatic test_full_queue();
      int i;
      tight_timing = 1'b1;
      while (mailbox_model.size() < fmq_pkg::DEPTH)
         send_item(make_random_item(100, 0));
      for (i = 0; i < 3; i++)
         send_item(make_random_item(100, 0));
      send_item(make_item(fmq_pkg::MODE_COUNT, PRIO_SPAM, 1, KIND_INFO, 1, 0, 1));
      send_item(make_item(MODE_NONE, PRIO_SPAM, 0, KIND_INFO, 0, 0, 0));
      tight_timing = 1'b0;
      // hold the sender off until the queue has answered everything
      pause_until_drained();
      for (i = 0; i < 64 && mailbox_model.size() != 0; i++) begin
         if ($urandom_range(0, 99) < 60)
            send_item(make_item(fmq_pkg::MODE_FETCH, PRIO_SPAM, 1, KIND_INFO, 1, 0, 1));
         else
            send_item(make_random_item(0, 100));
      end
      pause_until_drained();
   endtask

   task automatic test_random_traffic();
      int phase;
      int i;
      for (phase = 0; phase < PHASES; phase++) begin
         tight_timing = (phase % 5 == 4);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            case (phase % 3)
               0: send_item(make_random_item(60, 15));
               1: send_item(make_random_item(15, 60));
               default: send_item(make_random_item(35, 35));
            endcase
         end
         if (phase == PHASES / 2)
            pause_until_drained();
      end
      tight_timing = 1'b0;
      pause_until_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_queue();
      test_random_traffic();
      repeat (10) @(posedge clock);
      if (error_count == 0 && replies_due.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
